@@ src/burning_ship_pixel_iterator_top_defines.svh @@
// ============================================================================
// Burning-ship pixel iterator: assertion macros
// Shared concurrent-assertion forms used by the port checker.
// ============================================================================
`ifndef BURNING_SHIP_PIXEL_ITERATOR_TOP_DEFINES_SVH
`define BURNING_SHIP_PIXEL_ITERATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bsp_pkg.sv @@
// ============================================================================
// bsp_pkg
// Widths, reset values, register codes and shared types of the burning-ship
// pixel iterator.
// ============================================================================
package bsp_pkg;

    // fixed-point format of z and c
    localparam int FRAC_BITS = 26;

    localparam int COORD_W    = 12;
    localparam int COMP_W     = 32;
    localparam int CNT_W      = 16;
    localparam int THR_W      = 31;
    localparam int COLOR_W    = 24;
    localparam int LINE_W     = 16;
    localparam int BPP_W      = 6;
    localparam int STRIDE_W   = BPP_W - 3;
    localparam int OFFS_W     = 28;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // iteration datapath
    localparam int PROD_W = 2 * COMP_W;
    localparam int D_W    = PROD_W - FRAC_BITS + 1;
    localparam int N_W    = D_W + 1;
    localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};

    // update loop and result pipeline depths
    localparam int RING_STAGES = 4;
    localparam int TAG_W       = $clog2(RING_STAGES);
    localparam int OUT_STAGES  = 4;
    localparam int CAPACITY    = RING_STAGES + OUT_STAGES;
    localparam int CAP_W       = $clog2(CAPACITY + 1);

    // color * count / 3200: shift by 7, then divide by 25 via reciprocal
    localparam int COLOR_DIV   = 3200;
    localparam int DIV_SHIFT   = 7;
    localparam int DIV_ODD     = COLOR_DIV >> DIV_SHIFT;
    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIV_ODD;
    localparam int RECIP_W     = $clog2(RECIP);
    localparam int CPROD_W     = COLOR_W + CNT_W;
    localparam int W_W         = CPROD_W - DIV_SHIFT;
    localparam int MQ_W        = W_W + RECIP_W;
    localparam int Q_W         = MQ_W - RECIP_SHIFT;
    localparam int REM_W       = $clog2(3 * DIV_ODD);
    localparam logic [RECIP_W-1:0] RECIP_K    = RECIP_W'(RECIP);
    localparam logic [REM_W-1:0]   DIV_ODD_K  = REM_W'(DIV_ODD);
    localparam logic [REM_W-1:0]   DIV_ODD2_K = REM_W'(2 * DIV_ODD);

    // register reset values
    localparam logic [CNT_W-1:0]   ITER_LIMIT_RST = 16'd100;
    localparam logic [THR_W-1:0]   ESC_THR_RST    = 31'd268435456;
    localparam logic [COLOR_W-1:0] INSIDE_RST     = 24'h8E8FFA;
    localparam logic [COLOR_W-1:0] OUTSIDE_RST    = 24'hFFF6E9;
    localparam logic [LINE_W-1:0]  LINE_BYTES_RST = 16'd0;
    localparam logic [BPP_W-1:0]   BPP_RST        = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ITER_LIMIT = 3'd0,
        REG_ESC_THR    = 3'd1,
        REG_INSIDE     = 3'd2,
        REG_OUTSIDE    = 3'd3,
        REG_LINE_BYTES = 3'd4,
        REG_BPP        = 3'd5
    } cfg_reg_t;

    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [TAG_W-1:0]          tag_t;

    typedef struct packed {
        count_t             iteration_limit;
        logic [THR_W-1:0]   escape_threshold;
    } iter_cfg_t;

    typedef struct packed {
        logic   valid;
        count_t count;
        coord_t pixel_x;
        coord_t pixel_y;
    } ring_item_t;

endpackage

@@ src/bsp_iter_ring.sv @@
// ============================================================================
// bsp_iter_ring
// Four-stage recirculating update loop. Up to four pixels circulate, each
// doing one burning-ship update per trip; finished pixels leave in order.
// ============================================================================
module bsp_iter_ring (
    input  logic                aclk,
    input  logic                aresetn,
    input  bsp_pkg::iter_cfg_t  cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  bsp_pkg::coord_t     in_pixel_x,
    input  bsp_pkg::coord_t     in_pixel_y,
    input  bsp_pkg::comp_t      in_start_real,
    input  bsp_pkg::comp_t      in_start_imag,
    input  bsp_pkg::comp_t      in_point_real,
    input  bsp_pkg::comp_t      in_point_imag,
    input  logic                out_ready,
    output bsp_pkg::ring_item_t retire
);

    typedef struct packed {
        logic            valid;
        logic            done;
        bsp_pkg::tag_t   tag;
        bsp_pkg::count_t count;
        bsp_pkg::comp_t  cx;
        bsp_pkg::comp_t  cy;
        bsp_pkg::coord_t px;
        bsp_pkg::coord_t py;
    } slot_t;

    slot_t a_slot_reg, a_slot_next;
    slot_t b_slot_reg, b_slot_next;
    slot_t c_slot_reg, c_slot_next;
    slot_t d_slot_reg, d_slot_next;

    logic signed [bsp_pkg::PROD_W-1:0] a_sx_reg, a_sx_next;
    logic signed [bsp_pkg::PROD_W-1:0] a_sy_reg, a_sy_next;
    logic signed [bsp_pkg::PROD_W-1:0] a_pxy_reg, a_pxy_next;
    logic signed [bsp_pkg::D_W-1:0]    b_dx_reg, b_dx_next;
    logic signed [bsp_pkg::D_W-1:0]    b_dy_reg, b_dy_next;
    logic signed [bsp_pkg::N_W-1:0]    c_nx_reg, c_nx_next;
    logic signed [bsp_pkg::N_W-1:0]    c_ny_reg, c_ny_next;
    bsp_pkg::comp_t                    d_zx_reg, d_zx_next;
    bsp_pkg::comp_t                    d_zy_reg, d_zy_next;

    bsp_pkg::tag_t in_tag_reg, in_tag_next;
    bsp_pkg::tag_t ret_tag_reg, ret_tag_next;

    logic                              do_retire;
    logic                              do_inject;
    logic                              stop;
    bsp_pkg::comp_t                    zx_sel;
    bsp_pkg::comp_t                    zy_sel;
    logic [bsp_pkg::PROD_W-1:0]        mag_sum;
    logic [bsp_pkg::PROD_W-1:0]        esc_bound;
    logic signed [bsp_pkg::PROD_W-1:0] sq_diff;
    logic signed [bsp_pkg::PROD_W-1:0] dx_full;
    logic signed [bsp_pkg::PROD_W-1:0] dy_full;

    function automatic bsp_pkg::comp_t abs_sat(input logic signed [bsp_pkg::N_W-1:0] v);
        logic [bsp_pkg::N_W-1:0] mag;
        if (v[bsp_pkg::N_W-1]) begin
            mag = -v;
        end else begin
            mag = v;
        end
        if (|mag[bsp_pkg::N_W-1:bsp_pkg::COMP_W-1]) begin
            return bsp_pkg::COMP_MAX;
        end
        return mag[bsp_pkg::COMP_W-1:0];
    endfunction

    // oldest finished pixel leaves from the loop head
    assign do_retire = d_slot_reg.valid && d_slot_reg.done &&
                       (d_slot_reg.tag == ret_tag_reg) && out_ready;
    assign in_ready  = !d_slot_reg.valid || do_retire;
    assign do_inject = in_valid && in_ready;

    assign retire.valid   = do_retire;
    assign retire.count   = d_slot_reg.count;
    assign retire.pixel_x = d_slot_reg.px;
    assign retire.pixel_y = d_slot_reg.py;

    assign in_tag_next  = do_inject ? in_tag_reg + 1'b1 : in_tag_reg;
    assign ret_tag_next = do_retire ? ret_tag_reg + 1'b1 : ret_tag_reg;

    // stage A: squares and cross product
    always_comb begin
        a_slot_next       = d_slot_reg;
        a_slot_next.valid = d_slot_reg.valid && !do_retire;
        zx_sel            = d_zx_reg;
        zy_sel            = d_zy_reg;
        if (do_inject) begin
            a_slot_next.valid = 1'b1;
            a_slot_next.done  = 1'b0;
            a_slot_next.tag   = in_tag_reg;
            a_slot_next.count = '0;
            a_slot_next.cx    = in_point_real;
            a_slot_next.cy    = in_point_imag;
            a_slot_next.px    = in_pixel_x;
            a_slot_next.py    = in_pixel_y;
            zx_sel            = in_start_real;
            zy_sel            = in_start_imag;
        end
        a_sx_next  = zx_sel * zx_sel;
        a_sy_next  = zy_sel * zy_sel;
        a_pxy_next = zx_sel * zy_sel;
    end

    // stage B: escape test, scaled difference and cross term (floor shifts)
    always_comb begin
        mag_sum   = unsigned'(a_sx_reg) + unsigned'(a_sy_reg);
        esc_bound = {{(bsp_pkg::PROD_W - bsp_pkg::THR_W - bsp_pkg::FRAC_BITS){1'b0}},
                     cfg.escape_threshold, {bsp_pkg::FRAC_BITS{1'b0}}};
        stop      = (mag_sum >= esc_bound) || (a_slot_reg.count >= cfg.iteration_limit);
        sq_diff   = a_sx_reg - a_sy_reg;
        dx_full   = sq_diff >>> bsp_pkg::FRAC_BITS;
        dy_full   = a_pxy_reg >>> (bsp_pkg::FRAC_BITS - 1);

        b_slot_next      = a_slot_reg;
        b_slot_next.done = a_slot_reg.done || stop;
        if (!b_slot_next.done) begin
            b_slot_next.count = a_slot_reg.count + 1'b1;
        end
        b_dx_next = dx_full[bsp_pkg::D_W-1:0];
        b_dy_next = dy_full[bsp_pkg::D_W-1:0];
    end

    // stage C: add c
    always_comb begin
        c_slot_next = b_slot_reg;
        c_nx_next   = {b_dx_reg[bsp_pkg::D_W-1], b_dx_reg} +
                      {{(bsp_pkg::N_W - bsp_pkg::COMP_W){b_slot_reg.cx[bsp_pkg::COMP_W-1]}},
                       b_slot_reg.cx};
        c_ny_next   = {b_dy_reg[bsp_pkg::D_W-1], b_dy_reg} +
                      {{(bsp_pkg::N_W - bsp_pkg::COMP_W){b_slot_reg.cy[bsp_pkg::COMP_W-1]}},
                       b_slot_reg.cy};
    end

    // stage D: absolute value with saturation, back to the loop head
    always_comb begin
        d_slot_next = c_slot_reg;
        d_zx_next   = abs_sat(c_nx_reg);
        d_zy_next   = abs_sat(c_ny_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_slot_reg.valid <= 1'b0;
            b_slot_reg.valid <= 1'b0;
            c_slot_reg.valid <= 1'b0;
            d_slot_reg.valid <= 1'b0;
            in_tag_reg       <= '0;
            ret_tag_reg      <= '0;
        end else begin
            a_slot_reg  <= a_slot_next;
            b_slot_reg  <= b_slot_next;
            c_slot_reg  <= c_slot_next;
            d_slot_reg  <= d_slot_next;
            in_tag_reg  <= in_tag_next;
            ret_tag_reg <= ret_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_sx_reg  <= a_sx_next;
        a_sy_reg  <= a_sy_next;
        a_pxy_reg <= a_pxy_next;
        b_dx_reg  <= b_dx_next;
        b_dy_reg  <= b_dy_next;
        c_nx_reg  <= c_nx_next;
        c_ny_reg  <= c_ny_next;
        d_zx_reg  <= d_zx_next;
        d_zy_reg  <= d_zy_next;
    end

endmodule

@@ src/burning_ship_pixel_iterator_top.sv @@
// ============================================================================
// burning_ship_pixel_iterator_top
// Burning-ship escape-time iterator for one pixel per input word.
// ============================================================================
// Input word (s_*): pixel column/row, start z and point c in signed Q6.26.
// Result word (m_*): framebuffer byte offset, colour-scaled pixel value and
// iteration count, one result per input word, in input order.
// Config (cfg_*): write-only register port, always ready; write only while
// no pixel is in flight. Index 0..5 as in bsp_pkg::cfg_reg_t, others ignored.
// Each update runs through a 4-stage loop (multiply, escape test, add c,
// abs/saturate); four pixels share the loop, each doing one update per trip.
// A pixel stays in the loop for its updates, and longer while an older pixel
// is still iterating (results leave in input order), then passes through the
// result pipeline registers o1, o2, o3 and the output register.
// Up to four pixels are in the loop at once, so a new pixel can enter before
// earlier ones finish, as long as the slot at the loop head is free.
// Reset (synchronous, aresetn low) empties the loop and result pipeline
// and loads register defaults. When m_ready is low while a result is valid,
// the result pipeline holds; finished pixels keep circulating and s_ready
// is low while the loop-head slot is busy and not retiring. Nothing is dropped or repeated.
// ============================================================================
module burning_ship_pixel_iterator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bsp_pkg::COORD_W-1:0]         s_pixel_x,
    input  logic [bsp_pkg::COORD_W-1:0]         s_pixel_y,
    input  logic signed [bsp_pkg::COMP_W-1:0]   s_start_real,
    input  logic signed [bsp_pkg::COMP_W-1:0]   s_start_imag,
    input  logic signed [bsp_pkg::COMP_W-1:0]   s_point_real,
    input  logic signed [bsp_pkg::COMP_W-1:0]   s_point_imag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bsp_pkg::OFFS_W-1:0]          m_byte_offset,
    output logic [bsp_pkg::PIX_W-1:0]           m_pixel_value,
    output logic [bsp_pkg::CNT_W-1:0]           m_iteration_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // configuration registers
    logic [bsp_pkg::CNT_W-1:0]   iteration_limit_reg;
    logic [bsp_pkg::THR_W-1:0]   escape_threshold_reg;
    logic [bsp_pkg::COLOR_W-1:0] inside_color_reg;
    logic [bsp_pkg::COLOR_W-1:0] outside_color_reg;
    logic [bsp_pkg::LINE_W-1:0]  line_bytes_reg;
    logic [bsp_pkg::BPP_W-1:0]   bits_per_pixel_reg;

    bsp_pkg::iter_cfg_t  ring_cfg;
    bsp_pkg::ring_item_t ring_retire;
    logic                out_adv;
    logic                cfg_wr;

    // result pipeline
    logic                                         o1_valid_reg;
    logic [bsp_pkg::CNT_W-1:0]                    o1_count_reg;
    logic [bsp_pkg::CPROD_W-1:0]                  o1_cprod_reg, o1_cprod_next;
    logic [bsp_pkg::OFFS_W-1:0]                   o1_oy_reg, o1_oy_next;
    logic [bsp_pkg::COORD_W+bsp_pkg::STRIDE_W-1:0] o1_ox_reg, o1_ox_next;

    logic                        o2_valid_reg;
    logic [bsp_pkg::CNT_W-1:0]   o2_count_reg;
    logic [bsp_pkg::MQ_W-1:0]    o2_mq_reg, o2_mq_next;
    logic [bsp_pkg::REM_W-1:0]   o2_wlo_reg, o2_wlo_next;
    logic [bsp_pkg::OFFS_W-1:0]  o2_offs_reg, o2_offs_next;

    logic                        o3_valid_reg;
    logic [bsp_pkg::CNT_W-1:0]   o3_count_reg;
    logic [bsp_pkg::Q_W-1:0]     o3_q0_reg, o3_q0_next;
    logic [bsp_pkg::REM_W-1:0]   o3_wlo_reg;
    logic [bsp_pkg::OFFS_W-1:0]  o3_offs_reg;

    logic                        m_valid_reg;
    logic [bsp_pkg::OFFS_W-1:0]  m_byte_offset_reg;
    logic [bsp_pkg::PIX_W-1:0]   m_pixel_value_reg, m_pixel_value_next;
    logic [bsp_pkg::CNT_W-1:0]   m_iteration_count_reg;

    logic [bsp_pkg::COLOR_W-1:0]  color_sel;
    logic [bsp_pkg::STRIDE_W-1:0] stride;
    logic [bsp_pkg::W_W-1:0]      w_scaled;
    logic [bsp_pkg::REM_W-1:0]    rem;
    logic [1:0]                   q_fix;
    logic [bsp_pkg::Q_W-1:0]      q_final;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign ring_cfg.iteration_limit  = iteration_limit_reg;
    assign ring_cfg.escape_threshold = escape_threshold_reg;

    assign out_adv = !m_valid_reg || m_ready;

    bsp_iter_ring u_ring (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (ring_cfg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_pixel_x    (s_pixel_x),
        .in_pixel_y    (s_pixel_y),
        .in_start_real (s_start_real),
        .in_start_imag (s_start_imag),
        .in_point_real (s_point_real),
        .in_point_imag (s_point_imag),
        .out_ready     (out_adv),
        .retire        (ring_retire)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iteration_limit_reg  <= bsp_pkg::ITER_LIMIT_RST;
            escape_threshold_reg <= bsp_pkg::ESC_THR_RST;
            inside_color_reg     <= bsp_pkg::INSIDE_RST;
            outside_color_reg    <= bsp_pkg::OUTSIDE_RST;
            line_bytes_reg       <= bsp_pkg::LINE_BYTES_RST;
            bits_per_pixel_reg   <= bsp_pkg::BPP_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                bsp_pkg::REG_ITER_LIMIT: begin
                    iteration_limit_reg <= cfg_data[bsp_pkg::CNT_W-1:0];
                end
                bsp_pkg::REG_ESC_THR: begin
                    escape_threshold_reg <= cfg_data[bsp_pkg::THR_W-1:0];
                end
                bsp_pkg::REG_INSIDE: begin
                    inside_color_reg <= cfg_data[bsp_pkg::COLOR_W-1:0];
                end
                bsp_pkg::REG_OUTSIDE: begin
                    outside_color_reg <= cfg_data[bsp_pkg::COLOR_W-1:0];
                end
                bsp_pkg::REG_LINE_BYTES: begin
                    line_bytes_reg <= cfg_data[bsp_pkg::LINE_W-1:0];
                end
                bsp_pkg::REG_BPP: begin
                    bits_per_pixel_reg <= cfg_data[bsp_pkg::BPP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // limit reached selects the inside colour
        color_sel = (ring_retire.count == iteration_limit_reg) ?
                    inside_color_reg : outside_color_reg;
        stride        = bits_per_pixel_reg[bsp_pkg::BPP_W-1:3];
        o1_cprod_next = color_sel * ring_retire.count;
        o1_oy_next    = ring_retire.pixel_y * line_bytes_reg;
        o1_ox_next    = ring_retire.pixel_x * stride;

        // /3200 = >>7 then /25 via reciprocal, corrected below
        w_scaled     = o1_cprod_reg[bsp_pkg::CPROD_W-1:bsp_pkg::DIV_SHIFT];
        o2_mq_next   = w_scaled * bsp_pkg::RECIP_K;
        o2_wlo_next  = w_scaled[bsp_pkg::REM_W-1:0];
        o2_offs_next = o1_oy_reg +
                       {{(bsp_pkg::OFFS_W - bsp_pkg::COORD_W - bsp_pkg::STRIDE_W){1'b0}},
                        o1_ox_reg};

        o3_q0_next = o2_mq_reg[bsp_pkg::MQ_W-1:bsp_pkg::RECIP_SHIFT];

        // estimate is low by at most two; remainder is below 3*25
        rem     = o3_wlo_reg - (o3_q0_reg[bsp_pkg::REM_W-1:0] * bsp_pkg::DIV_ODD_K);
        q_fix   = {1'b0, rem >= bsp_pkg::DIV_ODD_K} + {1'b0, rem >= bsp_pkg::DIV_ODD2_K};
        q_final = o3_q0_reg + {{(bsp_pkg::Q_W - 2){1'b0}}, q_fix};
        m_pixel_value_next = {{(bsp_pkg::PIX_W - bsp_pkg::Q_W){1'b0}}, q_final};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o1_valid_reg <= 1'b0;
            o2_valid_reg <= 1'b0;
            o3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (out_adv) begin
            o1_valid_reg <= ring_retire.valid;
            o2_valid_reg <= o1_valid_reg;
            o3_valid_reg <= o2_valid_reg;
            m_valid_reg  <= o3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            o1_count_reg          <= ring_retire.count;
            o1_cprod_reg          <= o1_cprod_next;
            o1_oy_reg             <= o1_oy_next;
            o1_ox_reg             <= o1_ox_next;
            o2_count_reg          <= o1_count_reg;
            o2_mq_reg             <= o2_mq_next;
            o2_wlo_reg            <= o2_wlo_next;
            o2_offs_reg           <= o2_offs_next;
            o3_count_reg          <= o2_count_reg;
            o3_q0_reg             <= o3_q0_next;
            o3_wlo_reg            <= o2_wlo_reg;
            o3_offs_reg           <= o2_offs_reg;
            m_iteration_count_reg <= o3_count_reg;
            m_byte_offset_reg     <= o3_offs_reg;
            m_pixel_value_reg     <= m_pixel_value_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_byte_offset     = m_byte_offset_reg;
    assign m_pixel_value     = m_pixel_value_reg;
    assign m_iteration_count = m_iteration_count_reg;

endmodule

@@ src/bsp_checker.sv @@
// ============================================================================
// bsp_checker
// Port-level checks of the burning-ship pixel iterator, bound to the top.
// ============================================================================
`include "burning_ship_pixel_iterator_top_defines.svh"

module bsp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [bsp_pkg::OFFS_W-1:0]          m_byte_offset,
    input logic [bsp_pkg::PIX_W-1:0]           m_pixel_value,
    input logic [bsp_pkg::CNT_W-1:0]           m_iteration_count,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [bsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [bsp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [bsp_pkg::CAP_W-1:0] pending_reg, pending_next;
    logic [bsp_pkg::CNT_W-1:0] limit_reg, limit_next;
    logic                      in_acc;
    logic                      out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (in_acc && !out_acc) begin
            pending_next = pending_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            pending_next = pending_reg - 1'b1;
        end
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready && (cfg_index == bsp_pkg::REG_ITER_LIMIT)) begin
            limit_next = cfg_data[bsp_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            limit_reg   <= bsp_pkg::ITER_LIMIT_RST;
        end else begin
            pending_reg <= pending_next;
            limit_reg   <= limit_next;
        end
    end

    `BSP_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_byte_offset) && $stable(m_pixel_value) && $stable(m_iteration_count), "result word changed while stalled")
    `BSP_ASSERT_NOW(a_no_phantom, aclk, aresetn, m_valid, pending_reg != 0, "result word without a pending pixel")
    `BSP_ASSERT_NOW(a_capacity, aclk, aresetn, in_acc && !out_acc, pending_reg < bsp_pkg::CAPACITY, "more pixels accepted than the pipeline holds")
    `BSP_ASSERT_NOW(a_count_limit, aclk, aresetn, m_valid, m_iteration_count <= limit_reg, "iteration count above the limit")
    `BSP_ASSERT_NOW(a_zero_count, aclk, aresetn, m_valid && (m_iteration_count == 0), m_pixel_value == 0, "zero count with nonzero pixel value")

endmodule

bind burning_ship_pixel_iterator_top bsp_checker u_bsp_checker (.*);
